### src/tcsq_pkg.sv
package tcsq_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int VALUE_BITS  = 16;

    // widths fixed by the channel fields
    localparam int IN_VALUE_W = 16;
    localparam int COUNT_W    = 11;
    localparam int SUM_W      = 26;

    // entry count must hold MAX_ENTRIES itself
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // readout tree: groups of cells reduced into registers, then the groups reduced
    localparam int GROUP_SIZE = 32;
    localparam int NUM_GROUPS = (MAX_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SUM
    } t_state;

    function automatic t_val fit_value(logic [IN_VALUE_W-1:0] x);
        t_val r;
        r = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (i < IN_VALUE_W) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

    function automatic t_sum val_to_sum(t_val x);
        t_sum r;
        r = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (i < VALUE_BITS) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] fit_count(t_cnt x);
        logic [COUNT_W-1:0] r;
        r = '0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (i < CNT_W) begin
                r[i] = x[i];
            end
        end
        return r;
    endfunction

endpackage

### src/tcsq_if.sv
interface tcsq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface tcsq_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] match_count;
    logic [25:0] match_sum;
    logic        status;

    modport source (output valid, output match_count, output match_sum, output status,
                    input ready);
    modport sink   (input valid, input match_count, input match_sum, input status,
                    output ready);
endinterface

### src/tcsq_cell.sv
module tcsq_cell (
    input  logic                 i_clk,
    input  tcsq_pkg::t_cnt       i_index,
    input  tcsq_pkg::t_cnt       i_count,
    input  tcsq_pkg::t_val       i_key,
    input  tcsq_pkg::t_sum       i_key_sum,
    input  logic                 i_shift,
    input  logic                 i_left_gt,
    input  tcsq_pkg::t_val       i_left_value,
    input  tcsq_pkg::t_sum       i_left_sum,
    input  logic                 i_right_gt,
    output logic                 o_gt,
    output tcsq_pkg::t_val       o_value,
    output tcsq_pkg::t_sum       o_sum,
    output tcsq_pkg::t_cnt       o_hit_count,
    output tcsq_pkg::t_sum       o_hit_sum
);

    tcsq_pkg::t_val r_value;
    tcsq_pkg::t_sum r_sum;
    logic           w_hit;

    // empty cells act as +infinity so they always sit right of the key
    assign o_gt    = !(i_index < i_count) || (r_value > i_key);
    assign o_value = r_value;
    assign o_sum   = r_sum;

    // last cell at or below the key
    assign w_hit       = !o_gt && i_right_gt;
    assign o_hit_count = w_hit ? (i_index + tcsq_pkg::t_cnt'(1)) : '0;
    assign o_hit_sum   = w_hit ? r_sum : '0;

    always_ff @(posedge i_clk) begin
        if (i_shift && o_gt) begin
            r_value <= i_left_gt ? i_left_value : i_key;
            r_sum   <= i_left_sum + i_key_sum;
        end
    end

endmodule

### src/threshold_count_sum_query.sv
// Channel   Dir  Modport             Payload
// i_req     in   tcsq_in_if.sink     op[1:0], value[15:0]
// o_rsp     out  tcsq_out_if.source  match_count[10:0], match_sum[25:0], status
//
// Every request passes three steps: accept, the cell row (insert shift,
// count clear, or compare plus per-group OR), then the group OR and the
// result register. A new request is taken while the previous response waits.
// A stalled response holds the engine in its last step until the output
// register frees up. Reset clears the entry count and the handshake state;
// cell contents are left as they are.
module threshold_count_sum_query (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcsq_in_if.sink          i_req,
    tcsq_out_if.source       o_rsp
);

    localparam int MAX_ENTRIES = tcsq_pkg::MAX_ENTRIES;
    localparam int GROUP_SIZE  = tcsq_pkg::GROUP_SIZE;
    localparam int NUM_GROUPS  = tcsq_pkg::NUM_GROUPS;

    tcsq_pkg::t_state r_state, n_state;
    tcsq_pkg::t_op    r_op;
    tcsq_pkg::t_val   r_key;
    tcsq_pkg::t_sum   r_key_sum;
    tcsq_pkg::t_cnt   r_count;
    logic             r_drop;

    logic                          r_out_valid;
    logic [tcsq_pkg::COUNT_W-1:0]  r_out_count;
    tcsq_pkg::t_sum                r_out_sum;
    logic                          r_out_status;

    tcsq_pkg::t_cnt r_grp_cnt [NUM_GROUPS];
    tcsq_pkg::t_sum r_grp_sum [NUM_GROUPS];
    tcsq_pkg::t_cnt w_grp_cnt [NUM_GROUPS];
    tcsq_pkg::t_sum w_grp_sum [NUM_GROUPS];

    logic           w_gt    [MAX_ENTRIES];
    tcsq_pkg::t_val w_value [MAX_ENTRIES];
    tcsq_pkg::t_sum w_sum   [MAX_ENTRIES];
    tcsq_pkg::t_cnt w_hcnt  [MAX_ENTRIES];
    tcsq_pkg::t_sum w_hsum  [MAX_ENTRIES];

    logic           w_accept;
    logic           w_full;
    logic           w_shift;
    logic           w_out_free;
    tcsq_pkg::t_cnt w_res_cnt;
    tcsq_pkg::t_sum w_res_sum;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_full     = (r_count == tcsq_pkg::t_cnt'(MAX_ENTRIES));
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_shift    = (r_state == tcsq_pkg::S_EXEC) && (r_op == tcsq_pkg::OP_LOAD) && !w_full;

    // cell row
    for (genvar c = 0; c < MAX_ENTRIES; c++) begin : g_cell
        logic           w_lgt;
        tcsq_pkg::t_val w_lval;
        tcsq_pkg::t_sum w_lsum;
        logic           w_rgt;

        if (c == 0) begin : g_first
            assign w_lgt  = 1'b0;
            assign w_lval = '0;
            assign w_lsum = '0;
        end else begin : g_mid
            assign w_lgt  = w_gt[c-1];
            assign w_lval = w_value[c-1];
            assign w_lsum = w_sum[c-1];
        end

        if (c == MAX_ENTRIES - 1) begin : g_last
            assign w_rgt = 1'b1;
        end else begin : g_inner
            assign w_rgt = w_gt[c+1];
        end

        tcsq_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (tcsq_pkg::t_cnt'(c)),
            .i_count      (r_count),
            .i_key        (r_key),
            .i_key_sum    (r_key_sum),
            .i_shift      (w_shift),
            .i_left_gt    (w_lgt),
            .i_left_value (w_lval),
            .i_left_sum   (w_lsum),
            .i_right_gt   (w_rgt),
            .o_gt         (w_gt[c]),
            .o_value      (w_value[c]),
            .o_sum        (w_sum[c]),
            .o_hit_count  (w_hcnt[c]),
            .o_hit_sum    (w_hsum[c])
        );
    end

    // at most one cell hits, so OR works as the select
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        always_comb begin
            w_grp_cnt[g] = '0;
            w_grp_sum[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < MAX_ENTRIES) begin
                    w_grp_cnt[g] = w_grp_cnt[g] | w_hcnt[g * GROUP_SIZE + k];
                    w_grp_sum[g] = w_grp_sum[g] | w_hsum[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb begin
        w_res_cnt = '0;
        w_res_sum = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            w_res_cnt = w_res_cnt | r_grp_cnt[g];
            w_res_sum = w_res_sum | r_grp_sum[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tcsq_pkg::S_EXEC) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_grp_cnt[g] <= w_grp_cnt[g];
                r_grp_sum[g] <= w_grp_sum[g];
            end
        end
    end

    // control
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        case (r_state)
            tcsq_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = tcsq_pkg::S_EXEC;
                end
            end
            tcsq_pkg::S_EXEC: begin
                n_state = tcsq_pkg::S_SUM;
            end
            tcsq_pkg::S_SUM: begin
                if (w_out_free) begin
                    n_state = tcsq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcsq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcsq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= tcsq_pkg::t_op'(i_req.op);
            r_key     <= tcsq_pkg::fit_value(i_req.value);
            r_key_sum <= tcsq_pkg::val_to_sum(tcsq_pkg::fit_value(i_req.value));
        end
        if (r_state == tcsq_pkg::S_EXEC) begin
            r_drop <= (r_op == tcsq_pkg::OP_LOAD) && w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == tcsq_pkg::S_EXEC) begin
            case (r_op)
                tcsq_pkg::OP_LOAD: begin
                    if (!w_full) begin
                        r_count <= r_count + tcsq_pkg::t_cnt'(1);
                    end
                end
                tcsq_pkg::OP_CLEAR: begin
                    r_count <= '0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == tcsq_pkg::S_SUM && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tcsq_pkg::S_SUM && w_out_free) begin
            if (r_op == tcsq_pkg::OP_QUERY) begin
                r_out_count <= tcsq_pkg::fit_count(w_res_cnt);
                r_out_sum   <= w_res_sum;
            end else begin
                r_out_count <= '0;
                r_out_sum   <= '0;
            end
            r_out_status <= r_drop;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.match_count = r_out_count;
    assign o_rsp.match_sum   = r_out_sum;
    assign o_rsp.status      = r_out_status;

endmodule

### src/tcsq_checker.sv
module tcsq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [10:0] i_out_count,
    input  logic [25:0] i_out_sum,
    input  logic        i_out_status
);

    logic [1:0] r_pending;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sum)
            && $stable(i_out_count) && $stable(i_out_status))
        else $error("response changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("response without a request");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many requests in flight");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> i_out_count == 11'd0 && i_out_sum == 26'd0)
        else $error("dropped load reported a match");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_count == 11'd0 |-> i_out_sum == 26'd0)
        else $error("nonzero sum with no match");

endmodule

bind threshold_count_sum_query tcsq_checker u_tcsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_count  (o_rsp.match_count),
    .i_out_sum    (o_rsp.match_sum),
    .i_out_status (o_rsp.status)
);
